// ----- rtl/performance_basket_payoff_macros.svh -----
// Assertion macros for the performance basket payoff RTL.
// Depends on nothing; included by performance_basket_payoff, which carries the assertions.
`ifndef PERFORMANCE_BASKET_PAYOFF_MACROS_SVH
`define PERFORMANCE_BASKET_PAYOFF_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define PBP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define PBP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/pbp_pkg.sv -----
// Package for the performance basket payoff block: widths, constants,
// payload and control types, state encodings. Depends on nothing.
`default_nettype none

package pbp_pkg;

   localparam int NUM_ASSETS  = 4;
   localparam int MAX_ASSETS  = 4;
   localparam int PRICE_W     = 32;
   localparam int COEFF_W     = 16;
   localparam int PROD_W      = PRICE_W + COEFF_W + 1;
   localparam int BASKET_W    = 51;
   localparam int PAYOFF_W    = 48;
   localparam int FRAC_BITS   = 16;
   localparam int QUOT_INT_W  = PAYOFF_W - FRAC_BITS;
   localparam int DIV_STEPS   = PAYOFF_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
   localparam int CSR_INDEX_W = 3;

   localparam logic [PAYOFF_W-1:0] ONE_Q16  = PAYOFF_W'(1) << FRAC_BITS;
   localparam logic [PAYOFF_W-1:0] MAX_SAT  = {PAYOFF_W{1'b1}};
   localparam logic [COEFF_W-1:0]  COEFF_0_RESET = COEFF_W'(16384);
   localparam logic [COEFF_W-1:0]  COEFF_N_RESET = '0;

   localparam logic [CSR_INDEX_W-1:0] CSR_COEFF_0 = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_COEFF_1 = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_COEFF_2 = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_COEFF_3 = CSR_INDEX_W'(3);

   typedef struct packed {
      logic [PRICE_W-1:0] price_0;
      logic [PRICE_W-1:0] price_1;
      logic [PRICE_W-1:0] price_2;
      logic [PRICE_W-1:0] price_3;
      logic               last_row;
   } req_type;

   typedef struct packed {
      logic [PAYOFF_W-1:0] payoff;
      logic                bad_divisor;
   } rsp_type;

   typedef struct packed {
      logic                start;
      logic [BASKET_W-1:0] diff;
      logic [BASKET_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                done;
      logic [PAYOFF_W-1:0] quot;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_EVAL,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_CHECK,
      DV_RUN
   } div_state_type;

   function automatic logic [PAYOFF_W-1:0] sat_add(input logic [PAYOFF_W-1:0] a,
                                                   input logic [PAYOFF_W-1:0] b);
      logic [PAYOFF_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[PAYOFF_W] ? MAX_SAT : s[PAYOFF_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/pbp_lane.sv -----
// One basket lane: weights one asset price by its coefficient.
// Depends on pbp_pkg for widths.
`default_nettype none

module pbp_lane (
   input  wire logic                                clock,
   input  wire logic                                load,
   input  wire logic        [pbp_pkg::PRICE_W-1:0]  price,
   input  wire logic signed [pbp_pkg::COEFF_W-1:0]  coeff,
   output logic signed      [pbp_pkg::PROD_W-1:0]   product
);

   logic signed [pbp_pkg::PRICE_W:0]   price_s;
   logic signed [pbp_pkg::PROD_W-1:0]  product_in;
   logic signed [pbp_pkg::PROD_W-1:0]  product_ff;

   // The price is unsigned, so it gets a zero sign bit before the signed multiply.
   assign price_s    = $signed({1'b0, price});
   assign product_in = pbp_pkg::PROD_W'(price_s) * pbp_pkg::PROD_W'(coeff);

   always_ff @(posedge clock) begin
      if (load) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

`default_nettype wire

// ----- rtl/pbp_div.sv -----
// Radix-2 restoring divider for the return term floor(diff * 2^16 / divisor),
// saturated to 48 bits. Depends on pbp_pkg for widths, types and states.
`default_nettype none

module pbp_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pbp_pkg::div_cmd_type cmd,
   output pbp_pkg::div_rsp_type      rsp
);

   localparam int BW = pbp_pkg::BASKET_W;
   localparam int PW = pbp_pkg::PAYOFF_W;
   localparam int IW = pbp_pkg::QUOT_INT_W;
   localparam int FW = pbp_pkg::FRAC_BITS;
   localparam int CW = pbp_pkg::DIV_CNT_W;

   pbp_pkg::div_state_type state_ff, state_in;

   logic [BW-1:0] diff_ff;
   logic [BW-1:0] divisor_ff;
   logic [BW-1:0] rem_ff, rem_in;
   logic [PW-1:0] low_ff;
   logic [PW-1:0] quot_ff;
   logic [CW-1:0] count_ff;
   logic          done_ff;

   logic          load;
   logic          check;
   logic          step;
   logic          overflow;
   logic          last_step;
   logic [BW:0]   shifted;
   logic [BW:0]   trial;
   logic          fits;

   // The integer part reaches 2^32 exactly when diff / 2^32 is at least the divisor.
   assign overflow  = {{IW{1'b0}}, diff_ff[BW-1:IW]} >= divisor_ff;
   assign last_step = count_ff == CW'(pbp_pkg::DIV_STEPS - 1);

   assign shifted = {rem_ff, low_ff[PW-1]};
   assign trial   = shifted - {1'b0, divisor_ff};
   assign fits    = shifted >= {1'b0, divisor_ff};
   assign rem_in  = fits ? trial[BW-1:0] : shifted[BW-1:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pbp_pkg::DV_IDLE: begin
            if (cmd.start) state_in = pbp_pkg::DV_CHECK;
         end
         pbp_pkg::DV_CHECK: begin
            state_in = overflow ? pbp_pkg::DV_IDLE : pbp_pkg::DV_RUN;
         end
         pbp_pkg::DV_RUN: begin
            if (last_step) state_in = pbp_pkg::DV_IDLE;
         end
         default: state_in = pbp_pkg::DV_IDLE;
      endcase
   end

   always_comb begin
      load  = 1'b0;
      check = 1'b0;
      step  = 1'b0;
      case (state_ff)
         pbp_pkg::DV_IDLE:  load  = cmd.start;
         pbp_pkg::DV_CHECK: check = 1'b1;
         pbp_pkg::DV_RUN:   step  = 1'b1;
         default: begin
            load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pbp_pkg::DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (check && overflow) || (step && last_step);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         diff_ff    <= cmd.diff;
         divisor_ff <= cmd.divisor;
      end
      if (check) begin
         // The top bits of diff are already the partial remainder: their
         // quotient bits are zero once overflow is ruled out.
         rem_ff   <= {{IW{1'b0}}, diff_ff[BW-1:IW]};
         low_ff   <= {diff_ff[IW-1:0], {FW{1'b0}}};
         quot_ff  <= pbp_pkg::MAX_SAT;
         count_ff <= '0;
      end
      if (step) begin
         rem_ff   <= rem_in;
         low_ff   <= {low_ff[PW-2:0], 1'b0};
         quot_ff  <= {quot_ff[PW-2:0], fits};
         count_ff <= count_ff + CW'(1);
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

`default_nettype wire

// ----- rtl/performance_basket_payoff.sv -----
// Performance basket payoff, one path date per request word. Four multiplier
// lanes weight the prices in the cycle a word is taken, an adder stage forms the
// basket, and a bit-per-cycle divider forms max(basket / previous - 1, 0) in
// Q32.16. A date with a term holds off the next word for the divider's 48 quotient
// steps, a saturating one only for its check; a first date, a basket that does not
// rise or a non-positive previous basket skips the divider. On the last row a
// response word with 1.0 plus the saturated sum goes to an output register, and
// the next path may start while it waits. The user must write the coefficient
// registers through the csr port only while idle; the block does not enforce it.
`default_nettype none

`include "performance_basket_payoff_macros.svh"

module performance_basket_payoff (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire pbp_pkg::req_type                    req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output pbp_pkg::rsp_type                         rsp_data,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [pbp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [pbp_pkg::COEFF_W-1:0]         csr_data
);

   localparam int NA = pbp_pkg::NUM_ASSETS;
   localparam int BW = pbp_pkg::BASKET_W;
   localparam int PW = pbp_pkg::PAYOFF_W;

   pbp_pkg::state_type state_ff, state_in;

   logic signed [pbp_pkg::COEFF_W-1:0] coeff_ff [pbp_pkg::MAX_ASSETS];
   logic        [pbp_pkg::PRICE_W-1:0] price_arr [pbp_pkg::MAX_ASSETS];
   logic signed [pbp_pkg::PROD_W-1:0]  product [NA];

   logic signed [BW-1:0] basket_sum;
   logic signed [BW-1:0] basket_ff;
   logic signed [BW-1:0] prev_ff;
   logic                 have_prev_ff;
   logic [PW-1:0]        sum_ff;
   logic                 err_ff;
   logic                 last_ff;
   logic                 rsp_valid_ff;
   pbp_pkg::rsp_type     rsp_data_ff;

   logic accept;
   logic sum_en;
   logic eval_en;
   logic acc_en;
   logic finish_en;
   logic out_free;
   logic prev_bad;
   logic rising;

   pbp_pkg::div_cmd_type div_cmd;
   pbp_pkg::div_rsp_type div_rsp;

   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign prev_bad  = prev_ff[BW-1] || (prev_ff == '0);
   assign rising    = basket_ff > prev_ff;
   assign csr_ready = 1'b1;

   assign price_arr[0] = req_data.price_0;
   assign price_arr[1] = req_data.price_1;
   assign price_arr[2] = req_data.price_2;
   assign price_arr[3] = req_data.price_3;

   for (genvar g = 0; g < NA; g++) begin : g_lane
      pbp_lane u_lane (
         .clock   (clock),
         .load    (accept),
         .price   (price_arr[g]),
         .coeff   (coeff_ff[g]),
         .product (product[g])
      );
   end

   // Merge stage: the lane products are summed sign-extended to basket width.
   always_comb begin
      basket_sum = '0;
      for (int a = 0; a < NA; a++) begin
         basket_sum = basket_sum + BW'(product[a]);
      end
   end

   assign div_cmd.start   = eval_en && have_prev_ff && !prev_bad && rising;
   assign div_cmd.diff    = BW'(basket_ff - prev_ff);
   assign div_cmd.divisor = prev_ff;

   pbp_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pbp_pkg::ST_IDLE: begin
            if (req_valid) state_in = pbp_pkg::ST_SUM;
         end
         pbp_pkg::ST_SUM: state_in = pbp_pkg::ST_EVAL;
         pbp_pkg::ST_EVAL: begin
            state_in = div_cmd.start ? pbp_pkg::ST_DIV : pbp_pkg::ST_FINISH;
         end
         pbp_pkg::ST_DIV: begin
            if (div_rsp.done) state_in = pbp_pkg::ST_FINISH;
         end
         pbp_pkg::ST_FINISH: begin
            if (!last_ff || out_free) state_in = pbp_pkg::ST_IDLE;
         end
         default: state_in = pbp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      sum_en    = 1'b0;
      eval_en   = 1'b0;
      acc_en    = 1'b0;
      finish_en = 1'b0;
      case (state_ff)
         pbp_pkg::ST_IDLE:   req_stall = 1'b0;
         pbp_pkg::ST_SUM:    sum_en    = 1'b1;
         pbp_pkg::ST_EVAL:   eval_en   = 1'b1;
         pbp_pkg::ST_DIV:    acc_en    = div_rsp.done;
         pbp_pkg::ST_FINISH: finish_en = !last_ff || out_free;
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pbp_pkg::ST_IDLE;
         coeff_ff[0]  <= pbp_pkg::COEFF_0_RESET;
         coeff_ff[1]  <= pbp_pkg::COEFF_N_RESET;
         coeff_ff[2]  <= pbp_pkg::COEFF_N_RESET;
         coeff_ff[3]  <= pbp_pkg::COEFF_N_RESET;
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         sum_ff       <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               pbp_pkg::CSR_COEFF_0: coeff_ff[0] <= csr_data;
               pbp_pkg::CSR_COEFF_1: coeff_ff[1] <= csr_data;
               pbp_pkg::CSR_COEFF_2: coeff_ff[2] <= csr_data;
               pbp_pkg::CSR_COEFF_3: coeff_ff[3] <= csr_data;
               default: begin
                  coeff_ff[0] <= coeff_ff[0];
               end
            endcase
         end
         // A new word may replace the one leaving in the same cycle.
         if (finish_en && last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (eval_en && have_prev_ff && prev_bad) begin
            err_ff <= 1'b1;
         end
         if (acc_en) begin
            sum_ff <= pbp_pkg::sat_add(sum_ff, div_rsp.quot);
         end
         if (finish_en) begin
            if (last_ff) begin
               prev_ff      <= '0;
               have_prev_ff <= 1'b0;
               sum_ff       <= '0;
               err_ff       <= 1'b0;
            end else begin
               prev_ff      <= basket_ff;
               have_prev_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         last_ff <= req_data.last_row;
      end
      if (sum_en) begin
         basket_ff <= basket_sum;
      end
      if (finish_en && last_ff) begin
         rsp_data_ff.payoff      <= pbp_pkg::sat_add(pbp_pkg::ONE_Q16, sum_ff);
         rsp_data_ff.bad_divisor <= err_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A quotient only comes back while a date waits on it.
   `PBP_ASSERT_IMPL(a_div_done_in_div, clock, reset, div_rsp.done, state_ff == pbp_pkg::ST_DIV, "divider finished outside the divide state")
   // Before a path has a previous date nothing can have been summed or flagged.
   `PBP_ASSERT_IMPL(a_fresh_path_clear, clock, reset, !have_prev_ff, (sum_ff == '0) && !err_ff, "path state not clear before first date")
   // A response appears only when a last row finishes.
   `PBP_ASSERT_IMPL(a_rsp_from_last, clock, reset, $rose(rsp_valid_ff), $past(last_ff) && ($past(state_ff) == pbp_pkg::ST_FINISH), "response raised without a finished last row")

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for performance_basket_payoff: drives dated price words,
// predicts 1.0 plus the summed positive basket returns of each path, and checks
// every response word. Depends on pbp_pkg and the performance_basket_payoff RTL.

module tb;

   localparam int          QUIET_LIMIT  = 4000;
   localparam int          DRAIN_CYCLES = 64;
   localparam logic [47:0] SAT48        = {48{1'b1}};
   localparam logic [47:0] UNIT_Q16     = 48'h1_0000;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   pbp_pkg::req_type                req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   pbp_pkg::rsp_type                rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [pbp_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [pbp_pkg::COEFF_W-1:0]     csr_data = '0;

   // Shadow of the basket weights and of the per-path state.
   logic signed [15:0] weight [4];
   longint             last_basket;
   bit                 have_last;
   logic [47:0]        return_total;
   bit                 saw_bad;
   pbp_pkg::rsp_type   pending_payoffs [$];

   int errors = 0;
   int quiet = 0;
   int stall_left = 0;
   bit steady = 1'b0;

   performance_basket_payoff uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (steady) return 0;
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   function automatic logic [47:0] add_sat48(input logic [47:0] a, input logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? SAT48 : s[47:0];
   endfunction

   function automatic void clear_path();
      last_basket = 0;
      have_last = 1'b0;
      return_total = '0;
      saw_bad = 1'b0;
   endfunction

   // Advances the path state by one accepted date and queues the payoff on a last row.
   function automatic void track_row(input pbp_pkg::req_type row);
      logic [31:0]      price [4];
      longint           basket;
      longint           diff;
      logic [127:0]     quot;
      logic [47:0]      term;
      pbp_pkg::rsp_type res;
      price[0] = row.price_0;
      price[1] = row.price_1;
      price[2] = row.price_2;
      price[3] = row.price_3;
      basket = 0;
      for (int a = 0; a < 4; a++)
         basket += longint'({32'b0, price[a]}) * longint'(weight[a]);
      if (have_last) begin
         if (last_basket <= 0) begin
            saw_bad = 1'b1;
         end else if (basket > last_basket) begin
            diff = basket - last_basket;
            quot = ({64'b0, diff} << 16) / {64'b0, last_basket};
            term = (quot > {80'b0, SAT48}) ? SAT48 : quot[47:0];
            return_total = add_sat48(return_total, term);
         end
      end
      last_basket = basket;
      have_last = 1'b1;
      if (row.last_row) begin
         res.payoff = add_sat48(UNIT_Q16, return_total);
         res.bad_divisor = saw_bad;
         pending_payoffs.push_back(res);
         clear_path();
      end
   endfunction

   function automatic pbp_pkg::req_type pack_row(input logic [31:0] p0,
                                                 input logic [31:0] p1,
                                                 input logic [31:0] p2,
                                                 input logic [31:0] p3,
                                                 input logic last);
      pbp_pkg::req_type row;
      row.price_0 = p0;
      row.price_1 = p1;
      row.price_2 = p2;
      row.price_3 = p3;
      row.last_row = last;
      return row;
   endfunction

   function automatic logic [31:0] walk_price(input logic [31:0] lvl);
      longint step;
      longint v;
      step = longint'(lvl >> 3) + 1;
      v = longint'(lvl) + longint'($urandom_range(0, 32'(2 * step))) - step;
      if (v < 0) v = 0;
      if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
      return v[31:0];
   endfunction

   always @(posedge clock) begin : watch_ports
      pbp_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            track_row(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (pending_payoffs.size() == 0) begin
               $display("%0t: unexpected word: expected none, actual payoff %h bad_divisor %b",
                        $time, rsp_data.payoff, rsp_data.bad_divisor);
               errors++;
            end else begin
               want = pending_payoffs.pop_front();
               if (want.payoff !== rsp_data.payoff) begin
                  $display("%0t: payoff expected %h actual %h",
                           $time, want.payoff, rsp_data.payoff);
                  errors++;
               end
               if (want.bad_divisor !== rsp_data.bad_divisor) begin
                  $display("%0t: bad_divisor expected %b actual %b",
                           $time, want.bad_divisor, rsp_data.bad_divisor);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet = 0;
      else
         quiet++;
      if (quiet >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   // The receiver holds off in bursts whose length follows the sender's gaps.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = idle_len();
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_row(input pbp_pkg::req_type row);
      int gap;
      gap = idle_len();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= row;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drops valid, lets every expected word arrive, then lets the divider drain.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_payoffs.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [pbp_pkg::CSR_INDEX_W-1:0] index,
                            input logic [15:0] value);
      @(negedge clock);
      csr_index <= index;
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         pbp_pkg::CSR_COEFF_0: weight[0] = value;
         pbp_pkg::CSR_COEFF_1: weight[1] = value;
         pbp_pkg::CSR_COEFF_2: weight[2] = value;
         pbp_pkg::CSR_COEFF_3: weight[3] = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_weights(input logic [15:0] w0, input logic [15:0] w1,
                                input logic [15:0] w2, input logic [15:0] w3);
      wait_idle();
      csr_write(pbp_pkg::CSR_COEFF_0, w0);
      csr_write(pbp_pkg::CSR_COEFF_1, w1);
      csr_write(pbp_pkg::CSR_COEFF_2, w2);
      csr_write(pbp_pkg::CSR_COEFF_3, w3);
   endtask

   // Paths of one to eight dates that mostly drift from a random start level,
   // with scattered noise words and zero prices in between.
   task automatic run_paths(input int rows, input logic [31:0] span);
      int          sent;
      int          len;
      int          r;
      logic [31:0] level [4];
      sent = 0;
      while (sent < rows) begin
         len = $urandom_range(1, 8);
         for (int a = 0; a < 4; a++) level[a] = $urandom_range(1, span);
         for (int k = 0; k < len; k++) begin
            r = $urandom_range(0, 99);
            for (int a = 0; a < 4; a++) begin
               if (r < 12) level[a] = $urandom;
               else if (r < 15 && $urandom_range(0, 1) == 0) level[a] = '0;
               else level[a] = walk_price(level[a]);
            end
            send_row(pack_row(level[0], level[1], level[2], level[3], k == len - 1));
            sent++;
         end
      end
   endtask

   task automatic test_single_row_path();
      send_row(pack_row(32'h0001_0000, $urandom, $urandom, $urandom, 1'b1));
      send_row(pack_row(32'h0001_0000, $urandom, $urandom, $urandom, 1'b0));
      send_row(pack_row(32'h0001_8000, $urandom, $urandom, $urandom, 1'b1));
   endtask

   task automatic test_weight_extremes();
      write_weights(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_row(pack_row('1, '1, '1, '1, 1'b0));
      send_row(pack_row('1, '1, '1, '1, 1'b0));
      send_row(pack_row('0, '0, '0, '0, 1'b0));
      // The previous basket is zero here.
      send_row(pack_row('1, '1, '1, '1, 1'b1));
      write_weights(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_row(pack_row('1, '1, '1, '1, 1'b0));
      send_row(pack_row(32'd1, 32'd1, 32'd1, 32'd1, 1'b1));
   endtask

   task automatic test_term_saturation();
      write_weights(16'd1, 16'h4000, 16'h0000, 16'h0000);
      send_row(pack_row(32'd1, '0, $urandom, $urandom, 1'b0));
      send_row(pack_row('1, '1, $urandom, $urandom, 1'b0));
      send_row(pack_row(32'd1, '0, $urandom, $urandom, 1'b0));
      send_row(pack_row('1, '1, $urandom, $urandom, 1'b0));
      send_row(pack_row('1, '1, $urandom, $urandom, 1'b1));
      // Largest term that still fits the quotient.
      send_row(pack_row(32'd1, '0, $urandom, $urandom, 1'b0));
      send_row(pack_row('1, '0, $urandom, $urandom, 1'b1));
   endtask

   task automatic test_random_positive();
      repeat (4) begin
         write_weights($urandom_range(1, 32767), $urandom_range(1, 32767),
                       $urandom_range(1, 32767), $urandom_range(1, 32767));
         run_paths(60, 32'h0100_0000);
      end
   endtask

   task automatic test_random_signed();
      write_weights($urandom, $urandom, $urandom, $urandom);
      run_paths(60, 32'h7FFF_FFFF);
   endtask

   task automatic test_random_sparse();
      write_weights(16'h0000, 16'h7FFF, $urandom_range(1, 32767), 16'h0000);
      run_paths(30, 32'h0010_0000);
      write_weights(16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000);
      run_paths(30, 32'hFFFF_FFFF);
   endtask

   task automatic test_back_to_back();
      write_weights($urandom_range(1, 32767), $urandom_range(1, 32767),
                    $urandom_range(1, 32767), $urandom_range(1, 32767));
      steady = 1'b1;
      run_paths(60, 32'h0100_0000);
      wait_idle();
      steady = 1'b0;
   endtask

   initial begin
      weight[0] = 16'sd16384;
      weight[1] = '0;
      weight[2] = '0;
      weight[3] = '0;
      clear_path();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_single_row_path();
      test_weight_extremes();
      test_term_saturation();
      test_random_positive();
      test_random_signed();
      test_random_sparse();
      test_back_to_back();
      wait_idle();
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/pbp_pkg.sv
rtl/pbp_lane.sv
rtl/pbp_div.sv
rtl/performance_basket_payoff.sv
tb/tb.sv
